@@ sv/uaf_pkg.sv @@
// ----------------------------------------------------------------------------
// uaf_pkg
// Types, codes and the accent folding table shared by the UTF-8 to ASCII
// folding decoder.
// ----------------------------------------------------------------------------
package uaf_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNMAPPED  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   localparam logic [6:0] CHAR_QMARK = 7'h3F;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic [1:0] status;
      logic       run_last;
   } rsp_word_type;

   // results of one byte: qmark_count malformed marks, then an optional tail
   typedef struct packed {
      logic [2:0] qmark_count;
      logic       tail_valid;
      logic [6:0] tail_char;
      logic [1:0] tail_status;
   } desc_type;

   // fold a valid code point to ascii; zero when there is no fold
   function automatic logic [6:0] fold_cp(input logic [20:0] c);
      logic [6:0] f;
      f = 7'h00;
      if (c < 21'h80) begin
         f = c[6:0];
      end else begin
         case (c) inside
            21'h0C0, 21'h0C1, 21'h0C2, 21'h0C3, 21'h0C4,
            21'h0C5, 21'h0C6, 21'h100, 21'h102, 21'h104: f = 7'h41;
            21'h0E0, 21'h0E1, 21'h0E2, 21'h0E3, 21'h0E4,
            21'h0E5, 21'h0E6, 21'h101, 21'h103, 21'h105: f = 7'h61;
            21'h0C7, 21'h106, 21'h108, 21'h10A, 21'h10C: f = 7'h43;
            21'h0E7, 21'h107, 21'h109, 21'h10B, 21'h10D: f = 7'h63;
            21'h10E, 21'h110: f = 7'h44;
            21'h10F, 21'h111: f = 7'h64;
            21'h0C8, 21'h0C9, 21'h0CA, 21'h0CB, 21'h112,
            21'h114, 21'h116, 21'h118, 21'h11A: f = 7'h45;
            21'h0E8, 21'h0E9, 21'h0EA, 21'h0EB, 21'h113,
            21'h115, 21'h117, 21'h119, 21'h11B: f = 7'h65;
            21'h11C, 21'h11E, 21'h120, 21'h122: f = 7'h47;
            21'h11D, 21'h11F, 21'h121, 21'h123: f = 7'h67;
            21'h124, 21'h126: f = 7'h48;
            21'h125, 21'h127: f = 7'h68;
            21'h0CC, 21'h0CD, 21'h0CE, 21'h0CF, 21'h128,
            21'h12A, 21'h12C, 21'h12E, 21'h130: f = 7'h49;
            21'h0EC, 21'h0ED, 21'h0EE, 21'h0EF, 21'h129,
            21'h12B, 21'h12D, 21'h12F, 21'h131: f = 7'h69;
            21'h134: f = 7'h4A;
            21'h135: f = 7'h6A;
            21'h136: f = 7'h4B;
            21'h137: f = 7'h6B;
            21'h139, 21'h13B, 21'h13D, 21'h141: f = 7'h4C;
            21'h13A, 21'h13C, 21'h13E, 21'h142: f = 7'h6C;
            21'h0D1, 21'h143, 21'h145, 21'h147: f = 7'h4E;
            21'h0F1, 21'h144, 21'h146, 21'h148: f = 7'h6E;
            21'h0D2, 21'h0D3, 21'h0D4, 21'h0D5, 21'h0D6,
            21'h0D8, 21'h14C, 21'h14E, 21'h150: f = 7'h4F;
            21'h0F2, 21'h0F3, 21'h0F4, 21'h0F5, 21'h0F6,
            21'h0F8, 21'h14D, 21'h14F, 21'h151: f = 7'h6F;
            21'h154, 21'h156, 21'h158: f = 7'h52;
            21'h155, 21'h157, 21'h159: f = 7'h72;
            21'h15A, 21'h15C, 21'h15E, 21'h160, 21'h218: f = 7'h53;
            21'h0DF, 21'h15B, 21'h15D, 21'h15F, 21'h161,
            21'h219: f = 7'h73;
            21'h162, 21'h164, 21'h166, 21'h21A: f = 7'h54;
            21'h163, 21'h165, 21'h167, 21'h21B: f = 7'h74;
            21'h0D9, 21'h0DA, 21'h0DB, 21'h0DC, 21'h168,
            21'h16A, 21'h16C, 21'h16E, 21'h170, 21'h172: f = 7'h55;
            21'h0F9, 21'h0FA, 21'h0FB, 21'h0FC, 21'h169,
            21'h16B, 21'h16D, 21'h16F, 21'h171, 21'h173: f = 7'h75;
            21'h174: f = 7'h57;
            21'h175: f = 7'h77;
            21'h0DD, 21'h176, 21'h178: f = 7'h59;
            21'h0FD, 21'h0FF, 21'h177: f = 7'h79;
            21'h179, 21'h17B, 21'h17D: f = 7'h5A;
            21'h17A, 21'h17C, 21'h17E: f = 7'h7A;
            21'h0A0: f = 7'h20;
            21'h2018, 21'h2019, 21'h201A: f = 7'h27;
            21'h201C, 21'h201D, 21'h201E: f = 7'h22;
            21'h2013, 21'h2014, 21'h2212: f = 7'h2D;
            default: f = 7'h00;
         endcase
      end
      return f;
   endfunction

endpackage

@@ sv/utf8_to_ascii_folding_decoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ascii_folding_decoder_core
// UTF-8 validator that folds accented Latin and Turkish letters to ASCII.
//
//   channel  direction  word           handshake
//   req_     in         req_word_type  req_valid / req_ready
//   rsp_     out        rsp_word_type  rsp_valid / rsp_ready
//
// One byte is taken each cycle while the descriptor queue has room.
// A byte causes 0 to 4 results, and the back end holds its descriptor until all are out.
// The first result of a byte passes through a queue entry, then the output register.
// Synchronous reset clears the sequence state, the queue and the output register.
// QUEUE_DEPTH descriptors (2 or more) absorb output stalls before req_ready drops.
// ----------------------------------------------------------------------------
module utf8_to_ascii_folding_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  uaf_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output uaf_pkg::rsp_word_type rsp_word
);
   import uaf_pkg::*;

   logic     push_valid;
   logic     push_ready;
   desc_type push_desc;
   logic     head_valid;
   desc_type head_desc;
   logic     pop;

   uaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   uaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .head_valid (head_valid),
      .pop        (pop),
      .head_desc  (head_desc)
   );

   uaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

@@ sv/uaf_front.sv @@
// ----------------------------------------------------------------------------
// uaf_front
// Takes one byte a cycle while the queue has room, tracks the pending sequence
// and turns a byte that yields results into a descriptor for the back end.
// ----------------------------------------------------------------------------
module uaf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  uaf_pkg::req_word_type req_word,
   output logic                 push_valid,
   input  logic                 push_ready,
   output uaf_pkg::desc_type    push_desc
);
   import uaf_pkg::*;

   logic [7:0]  lead_ff, lead_in;
   logic [1:0]  held_ff, held_in;
   logic [1:0]  need_ff, need_in;
   logic [20:0] accum_ff, accum_in;

   logic [7:0]  b;
   logic        cont_ok;
   logic        fresh;
   logic [20:0] acc_shift;
   logic [6:0]  folded;
   desc_type    desc;
   logic        accept;

   assign b         = req_word.byte_in;
   assign acc_shift = {accum_ff[14:0], b[5:0]};
   assign folded    = fold_cp(acc_shift);
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lead_in  = lead_ff;
      held_in  = held_ff;
      need_in  = need_ff;
      accum_in = accum_ff;
      desc     = '0;
      fresh    = 1'b0;
      cont_ok  = (b[7:6] == 2'b10);

      if (held_ff != 2'd0) begin
         // second byte range checks against the lead
         if (held_ff == 2'd1 &&
             ((lead_ff == 8'hE0 && b < 8'hA0) || (lead_ff == 8'hED && b >= 8'hA0) ||
              (lead_ff == 8'hF0 && b < 8'h90) || (lead_ff == 8'hF4 && b > 8'h8F))) begin
            cont_ok = 1'b0;
         end
         if (cont_ok) begin
            if (held_ff >= need_ff) begin
               desc.tail_valid  = 1'b1;
               desc.tail_char   = (folded != 7'h00) ? folded : CHAR_QMARK;
               desc.tail_status = (folded != 7'h00) ? ST_OK : ST_UNMAPPED;
               lead_in  = 8'h00;
               held_in  = 2'd0;
               need_in  = 2'd0;
               accum_in = 21'h0;
            end else begin
               held_in  = held_ff + 2'd1;
               accum_in = acc_shift;
            end
         end else begin
            // breaking byte: mark every held byte, then decode it afresh
            desc.qmark_count = {1'b0, held_ff};
            lead_in  = 8'h00;
            held_in  = 2'd0;
            need_in  = 2'd0;
            accum_in = 21'h0;
            fresh    = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         if (b < 8'h80) begin
            desc.tail_valid  = 1'b1;
            desc.tail_char   = b[6:0];
            desc.tail_status = ST_OK;
         end else if (b >= 8'hC2 && b <= 8'hDF) begin
            lead_in  = b;
            held_in  = 2'd1;
            need_in  = 2'd1;
            accum_in = {16'h0, b[4:0]};
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            lead_in  = b;
            held_in  = 2'd1;
            need_in  = 2'd2;
            accum_in = {17'h0, b[3:0]};
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            lead_in  = b;
            held_in  = 2'd1;
            need_in  = 2'd3;
            accum_in = {18'h0, b[2:0]};
         end else begin
            desc.tail_valid  = 1'b1;
            desc.tail_char   = CHAR_QMARK;
            desc.tail_status = ST_MALFORMED;
         end
      end

      // flush whatever is still held at end of text
      if (req_word.end_of_text && held_in != 2'd0) begin
         desc.qmark_count = desc.qmark_count + {1'b0, held_in};
         lead_in  = 8'h00;
         held_in  = 2'd0;
         need_in  = 2'd0;
         accum_in = 21'h0;
      end
   end

   assign push_desc  = desc;
   assign push_valid = req_valid && (desc.qmark_count != 3'd0 || desc.tail_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= 8'h00;
         held_ff  <= 2'd0;
         need_ff  <= 2'd0;
         accum_ff <= 21'h0;
      end else if (accept) begin
         lead_ff  <= lead_in;
         held_ff  <= held_in;
         need_ff  <= need_in;
         accum_ff <= accum_in;
      end
   end

endmodule

@@ sv/uaf_queue.sv @@
// ----------------------------------------------------------------------------
// uaf_queue
// Short descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
module uaf_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  uaf_pkg::desc_type push_desc,
   output logic              head_valid,
   input  logic              pop,
   output uaf_pkg::desc_type head_desc
);
   import uaf_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   desc_type         entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ sv/uaf_back.sv @@
// ----------------------------------------------------------------------------
// uaf_back
// Expands each descriptor into result words, one word a cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module uaf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  uaf_pkg::desc_type     head_desc,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output uaf_pkg::rsp_word_type rsp_word
);
   import uaf_pkg::*;

   logic         busy_ff;
   desc_type     work_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   desc_type     cur;
   desc_type     rest;
   logic         cur_valid;
   logic         load;
   logic         emit;
   rsp_word_type item;

   assign cur       = busy_ff ? work_ff : head_desc;
   assign cur_valid = busy_ff || head_valid;
   assign load      = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid && load;
   assign pop       = emit && !busy_ff;

   always_comb begin
      rest = cur;
      if (cur.qmark_count != 3'd0) begin
         item.ascii_char = CHAR_QMARK;
         item.status     = ST_MALFORMED;
         item.run_last   = (cur.qmark_count == 3'd1) && !cur.tail_valid;
         rest.qmark_count = cur.qmark_count - 3'd1;
      end else begin
         item.ascii_char = cur.tail_char;
         item.status     = cur.tail_status;
         item.run_last   = 1'b1;
         rest.tail_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         busy_ff      <= (rest.qmark_count != 3'd0) || rest.tail_valid;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         work_ff     <= rest;
         rsp_word_ff <= item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ sv/uaf_checker.sv @@
// ----------------------------------------------------------------------------
// uaf_checker
// Port-level checks on the result channel of the folding decoder.
// ----------------------------------------------------------------------------
module uaf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input uaf_pkg::rsp_word_type rsp_word
);
   import uaf_pkg::*;

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("rsp_word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == ST_OK || rsp_word.status == ST_UNMAPPED ||
                     rsp_word.status == ST_MALFORMED))
      else $error("status code out of range");

   // any failure is reported as a question mark
   a_fail_qmark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |-> rsp_word.ascii_char == CHAR_QMARK)
      else $error("failed word is not a question mark");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind utf8_to_ascii_folding_decoder_core uaf_checker u_checker (.*);
